@@ design/scl_pkg.sv @@
// ---------------------------------------------------------------------------
// scl_pkg
// Shared types, codes and saturation helpers for the scissor clip stack.
// ---------------------------------------------------------------------------
package scl_pkg;

  // item kinds
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 2'd1;

  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned COORD_W    = 20;   // 1/16 point input fields
  localparam int unsigned SCALE_W    = 12;   // pixels per point, 1/256
  localparam int unsigned VPH_W      = 15;
  localparam int unsigned PROD_W     = 34;   // 21b signed x 13b signed
  localparam int unsigned WIDE_W     = 25;   // headroom for pre-saturation sums

  localparam logic [SCALE_W-1:0] SCALE_UNITY = 12'd256;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [14:0] w;
    logic        [14:0] h;
  } rect_t;

  typedef struct packed {
    logic mul_en;   // register the four scaled products
    logic edge_en;  // register the pixel rectangle
  } scl_ctrl_t;

  function automatic logic signed [15:0] sat_s16(input logic signed [WIDE_W-1:0] v);
    logic signed [15:0] r;
    if (v > 25'sd32767)       r = 16'sh7FFF;
    else if (v < -25'sd32768) r = 16'sh8000;
    else                      r = v[15:0];
    return r;
  endfunction

  function automatic logic [14:0] sat_u15(input logic signed [WIDE_W-1:0] v);
    logic [14:0] r;
    if (v < 25'sd0)          r = 15'd0;
    else if (v > 25'sd32767) r = 15'h7FFF;
    else                     r = v[14:0];
    return r;
  endfunction

endpackage

@@ design/scissor_clip_stack.sv @@
// ---------------------------------------------------------------------------
// scissor_clip_stack
// Nested scissor rectangle stack: push (scale, flip, intersect), pop, clear.
// ---------------------------------------------------------------------------
// Items are taken one at a time: accept, multiply, edge round, commit,
//   where commit waits while the last result is still unread; the
//   sequencer takes each item through the stack memory's single
//   read-then-write pass before the next beat.
// Reset: stack empty, pixel_scale 256, viewport_height 0. Stack memory is
//   not cleared; entries at or above the level are never used.
// ---------------------------------------------------------------------------
module scissor_clip_stack import scl_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // config write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  // item channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                kind,
  input  logic signed [COORD_W-1:0] rect_left,
  input  logic signed [COORD_W-1:0] rect_top,
  input  logic signed [COORD_W-1:0] rect_width,
  input  logic signed [COORD_W-1:0] rect_height,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      scissor_enable,
  output logic signed [15:0]        scissor_x,
  output logic signed [15:0]        scissor_y,
  output logic        [14:0]        scissor_w,
  output logic        [14:0]        scissor_h,
  output logic                      push_dropped
);

  localparam int unsigned LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_EDGE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [LVL_W-1:0]          level;
  logic [LVL_W-1:0]          level_next;

  logic [SCALE_W-1:0]        pixel_scale;
  logic [VPH_W-1:0]          viewport_height;

  // held item
  logic [1:0]                kind_q;
  logic signed [COORD_W-1:0] left_q;
  logic signed [COORD_W-1:0] top_q;
  logic signed [COORD_W-1:0] width_q;
  logic signed [COORD_W-1:0] height_q;

  // stack memory
  rect_t                     mem [STACK_DEPTH];
  rect_t                     top_rd;
  logic [LVL_W-1:0]          rd_sel;
  logic                      wr_en;
  rect_t                     res;
  logic                      dropped;

  rect_t                     new_rect;
  rect_t                     isect;
  scl_ctrl_t                 ctrl;

  logic                      accept;
  logic                      commit;
  logic                      full;
  logic                      has_top;

  logic signed [15:0]        x1;
  logic signed [15:0]        y1;
  logic signed [16:0]        nx2;
  logic signed [16:0]        ox2;
  logic signed [16:0]        ny2;
  logic signed [16:0]        oy2;
  logic signed [16:0]        x2;
  logic signed [16:0]        y2;
  logic signed [17:0]        dx;
  logic signed [17:0]        dy;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign commit    = (state == S_DONE) && (!out_valid || out_ready);
  assign full      = (level == LVL_FULL);
  assign has_top   = (level != '0);

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_scale     <= SCALE_UNITY;
      viewport_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PIXEL_SCALE:     pixel_scale     <= cfg_data[SCALE_W-1:0];
        REG_VIEWPORT_HEIGHT: viewport_height <= cfg_data[VPH_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_MUL;
      S_MUL:   state_next = S_EDGE;
      S_EDGE:  state_next = S_DONE;
      S_DONE:  if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= kind;
      left_q   <= rect_left;
      top_q    <= rect_top;
      width_q  <= rect_width;
      height_q <= rect_height;
    end
  end

  assign ctrl.mul_en  = (state == S_MUL);
  assign ctrl.edge_en = (state == S_EDGE);

  scl_scale u_scale (
    .clk             (clk),
    .ctrl            (ctrl),
    .left            (left_q),
    .top             (top_q),
    .width           (width_q),
    .height          (height_q),
    .pixel_scale     (pixel_scale),
    .viewport_height (viewport_height),
    .rect            (new_rect)
  );

  // Read the entry the item needs on the accept beat: the one under the top
  // for a pop, the top otherwise. The write lands in S_DONE, well clear of
  // the next read, so no forwarding is needed.
  assign rd_sel = (kind == KIND_POP) ? LVL_W'(level - LVL_W'(2)) : LVL_W'(level - LVL_W'(1));

  always_ff @(posedge clk) begin
    if (wr_en) mem[level[ADDR_W-1:0]] <= res;
    if (accept) top_rd <= mem[rd_sel[ADDR_W-1:0]];
  end

  // intersection with the current top
  always_comb begin
    x1  = (new_rect.x > top_rd.x) ? new_rect.x : top_rd.x;
    y1  = (new_rect.y > top_rd.y) ? new_rect.y : top_rd.y;
    nx2 = 17'(new_rect.x) + $signed({2'b00, new_rect.w});
    ox2 = 17'(top_rd.x)   + $signed({2'b00, top_rd.w});
    ny2 = 17'(new_rect.y) + $signed({2'b00, new_rect.h});
    oy2 = 17'(top_rd.y)   + $signed({2'b00, top_rd.h});
    x2  = (nx2 < ox2) ? nx2 : ox2;
    y2  = (ny2 < oy2) ? ny2 : oy2;
    dx  = 18'(x2) - 18'(x1);
    dy  = 18'(y2) - 18'(y1);
    isect.x = x1;
    isect.y = y1;
    isect.w = sat_u15(WIDE_W'(dx));
    isect.h = sat_u15(WIDE_W'(dy));
  end

  // stack update and reported top
  always_comb begin
    level_next = level;
    res        = top_rd;
    dropped    = 1'b0;
    wr_en      = 1'b0;
    case (kind_q)
      KIND_PUSH: begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          res        = has_top ? isect : new_rect;
          wr_en      = commit;
          level_next = LVL_W'(level + 1'b1);
        end
      end
      KIND_POP: begin
        if (has_top) level_next = LVL_W'(level - 1'b1);
      end
      KIND_CLEAR: begin
        level_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) level <= '0;
    else if (commit) level <= level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register; empty stack reports all zero
  always_ff @(posedge clk) begin
    if (commit) begin
      push_dropped   <= dropped;
      scissor_enable <= (level_next != '0);
      if (level_next != '0) begin
        scissor_x <= res.x;
        scissor_y <= res.y;
        scissor_w <= res.w;
        scissor_h <= res.h;
      end else begin
        scissor_x <= '0;
        scissor_y <= '0;
        scissor_w <= '0;
        scissor_h <= '0;
      end
    end
  end

  // level never runs past the memory
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_FULL)
    else $error("stack level beyond depth");

  // a write to the stack always grows it by one
  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> level == LVL_W'($past(level) + 1'b1))
    else $error("stack write without level increment");

  // a refused push only happens on a full, hence enabled, stack
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && push_dropped) |-> scissor_enable)
    else $error("push dropped on a stack that is not full");

  // a taken beat always starts the multiply step
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_MUL)
    else $error("sequencer did not start after accept");

endmodule

@@ design/scl_scale.sv @@
// ---------------------------------------------------------------------------
// scl_scale
// Two-stage datapath: point rectangle to saturated pixel rectangle.
// ---------------------------------------------------------------------------
module scl_scale import scl_pkg::*; (
  input  logic                      clk,
  input  scl_ctrl_t                 ctrl,
  input  logic signed [COORD_W-1:0] left,
  input  logic signed [COORD_W-1:0] top,
  input  logic signed [COORD_W-1:0] width,
  input  logic signed [COORD_W-1:0] height,
  input  logic        [SCALE_W-1:0] pixel_scale,
  input  logic        [VPH_W-1:0]   viewport_height,
  output rect_t                     rect
);

  logic        [SCALE_W-1:0]  s_eff;
  logic signed [SCALE_W:0]    op_s;
  logic signed [COORD_W-1:0]  w_c;
  logic signed [COORD_W-1:0]  h_c;
  logic signed [COORD_W:0]    op_l;
  logic signed [COORD_W:0]    op_t;
  logic signed [COORD_W:0]    op_r;
  logic signed [COORD_W:0]    op_b;

  logic signed [PROD_W-1:0]   p_l;
  logic signed [PROD_W-1:0]   p_t;
  logic signed [PROD_W-1:0]   p_r;
  logic signed [PROD_W-1:0]   p_b;

  logic signed [PROD_W-1:0]   r_up;
  logic signed [PROD_W-1:0]   b_up;
  logic signed [21:0]         sx;
  logic signed [21:0]         sy;
  logic signed [21:0]         sx2;
  logic signed [21:0]         sy2;
  logic signed [22:0]         dw;
  logic signed [22:0]         dh;
  logic signed [22:0]         nw;
  logic signed [22:0]         nh;
  logic signed [WIDE_W-1:0]   ny;

  // stage 1: clamp negative sizes to zero, scale by pixel_scale (zero acts as unity)
  always_comb begin
    s_eff = (pixel_scale == '0) ? SCALE_UNITY : pixel_scale;
    op_s  = $signed({1'b0, s_eff});
    w_c   = width[COORD_W-1]  ? '0 : width;
    h_c   = height[COORD_W-1] ? '0 : height;
    op_l  = $signed({left[COORD_W-1], left});
    op_t  = $signed({top[COORD_W-1], top});
    op_r  = op_l + $signed({w_c[COORD_W-1], w_c});
    op_b  = op_t + $signed({h_c[COORD_W-1], h_c});
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      p_l <= op_l * op_s;
      p_t <= op_t * op_s;
      p_r <= op_r * op_s;
      p_b <= op_b * op_s;
    end
  end

  // stage 2: floor near edges, ceil far edges (1/4096 px), flip y
  always_comb begin
    r_up = p_r + 34'sd4095;
    b_up = p_b + 34'sd4095;
    sx   = $signed(p_l[PROD_W-1:12]);
    sy   = $signed(p_t[PROD_W-1:12]);
    sx2  = $signed(r_up[PROD_W-1:12]);
    sy2  = $signed(b_up[PROD_W-1:12]);
    dw   = 23'(sx2) - 23'(sx);
    dh   = 23'(sy2) - 23'(sy);
    nw   = dw[22] ? '0 : dw;
    nh   = dh[22] ? '0 : dh;
    ny   = $signed({10'd0, viewport_height}) - (WIDE_W'(sy) + WIDE_W'(nh));
  end

  always_ff @(posedge clk) begin
    if (ctrl.edge_en) begin
      rect.x <= sat_s16(WIDE_W'(sx));
      rect.y <= sat_s16(ny);
      rect.w <= sat_u15(WIDE_W'(nw));
      rect.h <= sat_u15(WIDE_W'(nh));
    end
  end

endmodule

@@ dv/tb_scissor_clip_stack.sv @@
// ----------------------------------------------------------------------------
// tb_scissor_clip_stack
// Self-checking bench for the scissor clip stack. A tracker class follows the
// push/pop/clear effect of every accepted item and queues the rectangle the
// block should report. Each result beat is then compared field by field. A
// directed burst walks the corner cases, and random phases follow. Each
// random phase programs the registers and sets an idle/stall pattern.
// ----------------------------------------------------------------------------
module tb_scissor_clip_stack;
  timeunit 1ns;
  timeprecision 1ps;

  import scl_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned LONG_HOLD   = 300;    // receiver hold-off, cycles
  localparam int unsigned TAIL_CYCLES = 10;     // > result latency
  localparam int unsigned PHASE_ITEMS = 100;

  // kind 3 is not decoded by the block; register index 3 maps to nothing
  localparam logic [1:0]           KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] width;
    logic signed [COORD_W-1:0] height;
  } item_t;

  // one result beat, packed in port order
  typedef struct packed {
    logic               enable;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [14:0] w;
    logic        [14:0] h;
    logic               dropped;
  } view_t;

  // --------------------------------------------------------------------------
  // Tracker: own copy of the stack and both registers, plus the queue of
  // rectangles still owed by the block.
  // --------------------------------------------------------------------------
  class clip_tracker;
    rect_t        levels[DEPTH];
    int unsigned  used;
    logic [11:0]  scale;
    logic [14:0]  vp_height;
    view_t        pending_views[$];
    int unsigned  failures;

    function new();
      used      = 0;
      scale     = SCALE_UNITY;
      vp_height = '0;
      failures  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PIXEL_SCALE:     scale     = data[11:0];
        REG_VIEWPORT_HEIGHT: vp_height = data[14:0];
        default: ;
      endcase
    endfunction

    // 1/4096 pixel products: arithmetic shift floors, negate-shift-negate ceils
    function longint floor_px(longint v);
      return v >>> 12;
    endfunction

    function longint ceil_px(longint v);
      return -((-v) >>> 12);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void note_item(item_t it);
      view_t  v;
      rect_t  n;
      rect_t  o;
      longint s, l, t, wd, ht, px, py, px2, py2, nw, nh;
      longint ax, ay, bx, by, x1, y1, x2, y2;
      v = '0;
      case (it.kind)
        KIND_PUSH: begin
          if (used >= DEPTH) begin
            v.dropped = 1'b1;
          end else begin
            // a zero scale behaves as unity
            s  = (scale == 0) ? longint'(SCALE_UNITY) : longint'(scale);
            l  = $signed(it.left);
            t  = $signed(it.top);
            wd = $signed(it.width);
            ht = $signed(it.height);
            if (wd < 0) wd = 0;
            if (ht < 0) ht = 0;
            px  = floor_px(l * s);
            py  = floor_px(t * s);
            px2 = ceil_px((l + wd) * s);
            py2 = ceil_px((t + ht) * s);
            nw  = clamp(px2 - px, 0, 64'sh7FFF_FFFF_FFFF_FFFF);
            nh  = clamp(py2 - py, 0, 64'sh7FFF_FFFF_FFFF_FFFF);
            // flip uses the unsaturated height
            n.x = 16'(clamp(px, -32768, 32767));
            n.y = 16'(clamp(longint'(vp_height) - (py + nh), -32768, 32767));
            n.w = 15'(clamp(nw, 0, 32767));
            n.h = 15'(clamp(nh, 0, 32767));
            if (used > 0) begin
              o  = levels[used-1];
              ax = $signed(n.x);
              ay = $signed(n.y);
              bx = $signed(o.x);
              by = $signed(o.y);
              x1 = (ax > bx) ? ax : bx;
              y1 = (ay > by) ? ay : by;
              x2 = ax + longint'(n.w);
              if (bx + longint'(o.w) < x2) x2 = bx + longint'(o.w);
              y2 = ay + longint'(n.h);
              if (by + longint'(o.h) < y2) y2 = by + longint'(o.h);
              n.x = 16'(x1);
              n.y = 16'(y1);
              n.w = 15'(clamp(x2 - x1, 0, 32767));
              n.h = 15'(clamp(y2 - y1, 0, 32767));
            end
            levels[used] = n;
            used++;
          end
        end
        KIND_POP:   if (used > 0) used--;
        KIND_CLEAR: used = 0;
        default: ;
      endcase
      if (used > 0) begin
        v.enable = 1'b1;
        v.x      = levels[used-1].x;
        v.y      = levels[used-1].y;
        v.w      = levels[used-1].w;
        v.h      = levels[used-1].h;
      end
      pending_views.insert(pending_views.size(), v);
    endfunction

    function void compare_field(string name, logic signed [16:0] want,
                                logic signed [16:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        failures++;
      end
    endfunction

    function void check_beat(view_t got);
      view_t want;
      if (pending_views.size() == 0) begin
        $error("result beat with no item outstanding");
        failures++;
        return;
      end
      want = pending_views.pop_front();
      compare_field("scissor_enable", 17'(want.enable), 17'(got.enable));
      compare_field("scissor_x", $signed(want.x), $signed(got.x));
      compare_field("scissor_y", $signed(want.y), $signed(got.y));
      compare_field("scissor_w", 17'(want.w), 17'(got.w));
      compare_field("scissor_h", 17'(want.h), 17'(got.h));
      compare_field("push_dropped", 17'(want.dropped), 17'(got.dropped));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every input starts at a known value; reset is high from time 0.
  // --------------------------------------------------------------------------
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                kind = KIND_POP;
  logic signed [COORD_W-1:0] rect_left = '0;
  logic signed [COORD_W-1:0] rect_top = '0;
  logic signed [COORD_W-1:0] rect_width = '0;
  logic signed [COORD_W-1:0] rect_height = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      scissor_enable;
  logic signed [15:0]        scissor_x;
  logic signed [15:0]        scissor_y;
  logic        [14:0]        scissor_w;
  logic        [14:0]        scissor_h;
  logic                      push_dropped;

  clip_tracker  tracker;
  int unsigned  send_idle_pct = 0;   // sender gap chance per beat, percent
  int unsigned  stall_pct = 0;       // receiver stall chance per cycle
  bit           hold_request = 1'b0; // asks the receiver for one long hold
  int unsigned  cycle_count;

  scissor_clip_stack #(.STACK_DEPTH(DEPTH)) i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: runs out only if a handshake never completes.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** scissor_clip_stack: FAILED **");
    $finish;
  end

  // Receiver: random stalls, and one long hold when asked. The hold is
  // counted here so the sender keeps offering beats meanwhile.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result beats are checked at the rising edge they are taken on.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_beat({scissor_enable, scissor_x, scissor_y,
                          scissor_w, scissor_h, push_dropped});
  end

  // --------------------------------------------------------------------------
  // Drivers. All are entered and left at a falling edge, so each input sees
  // at most one update per time step.
  // --------------------------------------------------------------------------

  // One item beat: optional gap first, then hold valid until taken.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= it.kind;
    rect_left   <= it.left;
    rect_top    <= it.top;
    rect_width  <= it.width;
    rect_height <= it.height;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_item(it);
    @(negedge clk);
  endtask

  // Sender goes quiet until every owed result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending_views.size() != 0);
  endtask

  // One config beat; cfg_valid is already high.
  task automatic write_beat(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Back-to-back register writes, only while the block is idle. The unused
  // index is poked too, and the scale beat carries junk above bit 11.
  task automatic program_regs(input logic [11:0] px_scale, input logic [14:0] vp_h);
    logic [2:0]            junk;
    logic [CFG_DATA_W-1:0] spare_data;
    junk       = 3'($urandom);
    spare_data = 15'($urandom);
    cfg_valid <= 1'b1;
    write_beat(REG_SPARE, spare_data);
    write_beat(REG_PIXEL_SCALE, {junk, px_scale});
    write_beat(REG_VIEWPORT_HEIGHT, vp_h);
    cfg_valid <= 1'b0;
  endtask

  // Random item. Mostly plausible widget rectangles (fractional points, a few
  // negative sizes); one in ten uses raw full-range fields. The kind mix
  // leans on pushes while filling and on pops while draining, so the stack
  // swings between empty and full.
  function automatic item_t random_item(input bit filling);
    item_t       it;
    int unsigned r;
    r = $urandom_range(99);
    if (filling)
      it.kind = (r < 75) ? KIND_PUSH : (r < 90) ? KIND_POP :
                (r < 93) ? KIND_CLEAR : KIND_UNUSED;
    else
      it.kind = (r < 30) ? KIND_PUSH : (r < 88) ? KIND_POP :
                (r < 92) ? KIND_CLEAR : KIND_UNUSED;
    if ($urandom_range(9) == 0) begin
      it.left   = 20'($urandom);
      it.top    = 20'($urandom);
      it.width  = 20'($urandom);
      it.height = 20'($urandom);
    end else begin
      it.left   = 20'(int'($urandom_range(14400)) - 1600);
      it.top    = 20'(int'($urandom_range(14400)) - 1600);
      it.width  = 20'(int'($urandom_range(9600)) - 160);
      it.height = 20'(int'($urandom_range(9600)) - 160);
    end
    return it;
  endfunction

  function automatic item_t make_item(input logic [1:0] k, input int l, input int t,
                                      input int w, input int h);
    item_t it;
    it.kind   = k;
    it.left   = 20'(l);
    it.top    = 20'(t);
    it.width  = 20'(w);
    it.height = 20'(h);
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    item_t       it;
    logic [11:0] px;
    logic [14:0] vh;
    bit          filling;
    tracker = new();
    filling = 1'b1;

    // reset is held from time 0 and released once
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    program_regs(SCALE_UNITY, 15'd480);

    // Directed burst at unity scale, no idling.
    // Empty-stack reports first: pop on empty and the unused kind.
    send_item(make_item(KIND_POP, 0, 0, 0, 0));
    send_item(make_item(KIND_UNUSED, -1, -1, -1, -1));
    // plain push with fractional left and width
    send_item(make_item(KIND_PUSH, 163, 320, 1605, 800));
    // negative width and height collapse to an empty rectangle
    send_item(make_item(KIND_PUSH, 800, -8, -5, -1));
    // field extremes, both ways round, to drive saturation
    send_item(make_item(KIND_PUSH, -524288, -524288, 524287, 524287));
    send_item(make_item(KIND_PUSH, 524287, 524287, 524287, 524287));
    send_item(make_item(KIND_UNUSED, 524287, -524288, 524287, -524288));
    send_item(make_item(KIND_POP, 0, 0, 0, 0));
    // fill to the brim, then one push that must be refused
    for (int k = 0; k < 14; k++) begin
      it = random_item(1'b1);
      it.kind = KIND_PUSH;
      send_item(it);
    end
    send_item(make_item(KIND_POP, 0, 0, 0, 0));
    send_item(make_item(KIND_CLEAR, 0, 0, 0, 0));
    drain();

    // Random phases: one register setting and one idle pattern each.
    for (int ph = 0; ph < 8; ph++) begin
      px = 12'($urandom_range(1, 4095));
      vh = 15'($urandom);
      case (ph)
        0: begin px = SCALE_UNITY; vh = 15'd480;   send_idle_pct = 0;  stall_pct = 0;  end
        1: begin px = 12'd1;       vh = 15'd0;     send_idle_pct = 52; stall_pct = 0;  end
        2: begin px = 12'd4095;    vh = 15'd32767; send_idle_pct = 0;  stall_pct = 52; end
        3: begin px = 12'd0;       vh = 15'd1080;  send_idle_pct = 28; stall_pct = 28; end
        4: begin                                   send_idle_pct = 0;  stall_pct = 0;  end
        5: begin px = 12'd512;     vh = 15'd720;   send_idle_pct = 52; stall_pct = 0;  end
        6: begin                                   send_idle_pct = 0;  stall_pct = 52; end
        default: begin                             send_idle_pct = 28; stall_pct = 28; end
      endcase
      program_regs(px, vh);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(19) == 0) filling = !filling;
        // long receiver hold while beats keep coming: the block backs up
        if (ph == 4 && k == 10) hold_request = 1'b1;
        // sender waits mid-phase until the block has emptied
        if (ph == 5 && k == PHASE_ITEMS / 2) drain();
        send_item(random_item(filling));
      end
      drain();
    end

    // quiet tail so that any stray beat still gets caught
    repeat (TAIL_CYCLES) @(negedge clk);
    if (tracker.failures == 0 && tracker.pending_views.size() == 0)
      $display("** scissor_clip_stack: PASSED **");
    else
      $display("** scissor_clip_stack: FAILED **");
    $finish;
  end

endmodule
